[hw/rtl/line_planar_to_rgb_interleave_macros.svh]
// Assertion helpers shared by the top, control and queue modules.
// Each module that uses them has ports i_clk and i_rst_n.
`ifndef LINE_PLANAR_TO_RGB_INTERLEAVE_MACROS_SVH
`define LINE_PLANAR_TO_RGB_INTERLEAVE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LP2RGB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LP2RGB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lp2rgb_pkg.sv]
`default_nettype none

package lp2rgb_pkg;

    // plane phase codes
    localparam logic [1:0] P_RED   = 2'd0;
    localparam logic [1:0] P_GREEN = 2'd1;
    localparam logic [1:0] P_BLUE  = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W        = 1;
    localparam logic [0:0] REG_LINE_WIDTH   = 1'd0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'd1;
    localparam int         CFG_DATA_W       = 16;

    localparam int LINE_WIDTH_W   = 13;
    localparam int IMAGE_HEIGHT_W = 16;

    // width for column/width compares, covers a line of up to 65536 pixels
    localparam int C_CMP_W = 17;

    // output queue depth
    localparam int C_FIFO_DEPTH = 4;

    typedef struct packed {
        logic [1:0] phase;
        logic       line_done;
        logic       last_row;
    } t_step;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       image_end;
    } t_pixel;

endpackage

`default_nettype wire

[hw/rtl/line_planar_to_rgb_interleave.sv]
`default_nettype none

// Line-planar to pixel-interleaved RGB converter. Each image row arrives as a
// red line, a green line and a blue line of line_width bytes each; red and
// green are kept in two line stores and every blue byte leaves as one pixel
// with the stored red and green of its column. image_end marks the last pixel
// of an image of image_height rows, after which the counters start over. One
// byte is taken every clock unless o_stall is raised: a pixel passes through
// the registered line-store read and then the output queue.
// The four-entry output queue raises the registered o_stall once three
// results are held or in flight, so input halts only under output back-pressure.
// Write configuration only while no pixel is outstanding.

`include "line_planar_to_rgb_interleave_macros.svh"

module line_planar_to_rgb_interleave #(
    parameter int MAX_LINE_WIDTH = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [7:0]                        i_plane_byte,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic      [7:0]                        o_red,
    output logic      [7:0]                        o_green,
    output logic      [7:0]                        o_blue,
    output logic                                   o_image_end,
    input  wire logic                              i_cfg_we,
    input  wire logic [lp2rgb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lp2rgb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lp2rgb_pkg::*;

    localparam int COL_W = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;

    logic [LINE_WIDTH_W-1:0]   r_line_width;
    logic [IMAGE_HEIGHT_W-1:0] r_image_height;
    logic                      accept;
    logic [COL_W-1:0]          col;
    t_step                     step;
    logic                      is_blue;
    logic                      we_red;
    logic                      we_green;
    logic                      n_res_valid;
    logic                      r_res_valid;
    logic [7:0]                r_res_blue;
    logic                      r_res_end;
    logic [7:0]                st_red;
    logic [7:0]                st_green;
    t_pixel                    res_pixel;
    t_pixel                    out_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LINE_WIDTH_W'(4096);
            r_image_height <= IMAGE_HEIGHT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LINE_WIDTH:   r_line_width   <= i_cfg_data[LINE_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[IMAGE_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept      = i_valid && !o_stall;
    assign is_blue     = step.phase == P_BLUE;
    assign we_green    = accept && (step.phase == P_GREEN);
    // the unused phase code writes the red line like red does
    assign we_red      = accept && (step.phase != P_GREEN) && !is_blue;
    assign n_res_valid = accept && is_blue;

    lp2rgb_ctrl #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .COL_W          (COL_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_line_width   (r_line_width),
        .i_image_height (r_image_height),
        .o_col          (col),
        .o_step         (step)
    );

    lp2rgb_store #(
        .DEPTH  (MAX_LINE_WIDTH),
        .ADDR_W (COL_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_we_red   (we_red),
        .i_we_green (we_green),
        .i_rd_en    (n_res_valid),
        .i_addr     (col),
        .i_wdata    (i_plane_byte),
        .o_red      (st_red),
        .o_green    (st_green)
    );

    // blue byte and end flag travel alongside the store read
    always_ff @(posedge i_clk) begin
        if (n_res_valid) begin
            r_res_blue <= i_plane_byte;
            r_res_end  <= step.line_done && step.last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= n_res_valid;
        end
    end

    assign res_pixel.red       = st_red;
    assign res_pixel.green     = st_green;
    assign res_pixel.blue      = r_res_blue;
    assign res_pixel.image_end = r_res_end;

    lp2rgb_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_res_valid),
        .i_push_next (n_res_valid),
        .i_pixel     (res_pixel),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_pixel     (out_pixel),
        .o_full      (o_stall)
    );

    assign o_red       = out_pixel.red;
    assign o_green     = out_pixel.green;
    assign o_blue      = out_pixel.blue;
    assign o_image_end = out_pixel.image_end;

    `LP2RGB_ASSERT_NEXT(a_blue_gives_result, i_valid && !o_stall && step.phase == P_BLUE, r_res_valid, "blue transfer produced no result")
    `LP2RGB_ASSERT_NEXT(a_no_stray_result, !(i_valid && !o_stall && step.phase == P_BLUE), !r_res_valid, "result without blue transfer")

endmodule

`default_nettype wire

[hw/rtl/lp2rgb_ctrl.sv]
`default_nettype none

`include "line_planar_to_rgb_interleave_macros.svh"

module lp2rgb_ctrl #(
    parameter int MAX_LINE_WIDTH = 4096,
    parameter int COL_W          = 12
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_accept,
    input  wire logic [lp2rgb_pkg::LINE_WIDTH_W-1:0]   i_line_width,
    input  wire logic [lp2rgb_pkg::IMAGE_HEIGHT_W-1:0] i_image_height,
    output logic      [COL_W-1:0]                      o_col,
    output lp2rgb_pkg::t_step                          o_step
);
    import lp2rgb_pkg::*;

    logic [COL_W-1:0]          r_col;
    logic [COL_W-1:0]          n_col;
    logic [1:0]                r_phase;
    logic [1:0]                n_phase;
    logic [IMAGE_HEIGHT_W-1:0] r_row;
    logic [IMAGE_HEIGHT_W-1:0] n_row;
    logic [C_CMP_W-1:0]        lw_ext;
    logic [C_CMP_W-1:0]        w_eff;
    logic [IMAGE_HEIGHT_W-1:0] h_m1;
    logic                      line_done;
    logic                      last_row;

    // clamp the width into 1..MAX_LINE_WIDTH, height 0 acts as 1
    always_comb begin
        lw_ext = C_CMP_W'(i_line_width);
        if (lw_ext == '0) begin
            w_eff = C_CMP_W'(1);
        end else if (lw_ext > C_CMP_W'(MAX_LINE_WIDTH)) begin
            w_eff = C_CMP_W'(MAX_LINE_WIDTH);
        end else begin
            w_eff = lw_ext;
        end
        h_m1 = (i_image_height == '0) ? '0 : i_image_height - 1'b1;
    end

    assign line_done = (C_CMP_W'(r_col) + C_CMP_W'(1)) >= w_eff;
    assign last_row  = r_row >= h_m1;

    assign o_col            = r_col;
    assign o_step.phase     = r_phase;
    assign o_step.line_done = line_done;
    assign o_step.last_row  = last_row;

    always_comb begin
        n_col   = r_col;
        n_phase = r_phase;
        n_row   = r_row;
        if (i_accept) begin
            if (line_done) begin
                n_col = '0;
                unique case (r_phase)
                    P_BLUE: begin
                        n_phase = P_RED;
                        n_row   = last_row ? '0 : r_row + 1'b1;
                    end
                    P_GREEN: begin
                        n_phase = P_BLUE;
                    end
                    default: begin
                        n_phase = P_GREEN;
                    end
                endcase
            end else begin
                n_col = r_col + 1'b1;
                // unreachable code falls back to red
                if (r_phase > P_BLUE) begin
                    n_phase = P_RED;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_phase <= P_RED;
            r_row   <= '0;
        end else begin
            r_col   <= n_col;
            r_phase <= n_phase;
            r_row   <= n_row;
        end
    end

    `LP2RGB_ASSERT_NEXT(a_blue_line_wraps, i_accept && r_phase == P_BLUE && line_done, r_phase == P_RED && r_col == '0, "blue line end did not return to red plane")
    `LP2RGB_ASSERT_NEXT(a_col_advances, i_accept && !line_done, r_col == COL_W'($past(r_col) + 1'b1), "column did not advance")

endmodule

`default_nettype wire

[hw/rtl/lp2rgb_store.sv]
`default_nettype none

module lp2rgb_store #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_we_red,
    input  wire logic              i_we_green,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [7:0]        i_wdata,
    output logic      [7:0]        o_red,
    output logic      [7:0]        o_green
);

    logic [7:0] r_red_mem   [DEPTH];
    logic [7:0] r_green_mem [DEPTH];
    logic [7:0] r_red_q;
    logic [7:0] r_green_q;

    always_ff @(posedge i_clk) begin
        if (i_we_red) begin
            r_red_mem[i_addr] <= i_wdata;
        end
        if (i_we_green) begin
            r_green_mem[i_addr] <= i_wdata;
        end
        // registered read, holds between blue bytes
        if (i_rd_en) begin
            r_red_q   <= r_red_mem[i_addr];
            r_green_q <= r_green_mem[i_addr];
        end
    end

    assign o_red   = r_red_q;
    assign o_green = r_green_q;

endmodule

`default_nettype wire

[hw/rtl/lp2rgb_skid.sv]
`default_nettype none

`include "line_planar_to_rgb_interleave_macros.svh"

module lp2rgb_skid (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic               i_push_next,
    input  wire lp2rgb_pkg::t_pixel i_pixel,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output lp2rgb_pkg::t_pixel      o_pixel,
    output logic                    o_full
);
    import lp2rgb_pkg::*;

    localparam int PTR_W = (C_FIFO_DEPTH > 1) ? $clog2(C_FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(C_FIFO_DEPTH + 1);

    t_pixel           r_buf [C_FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_stall;
    logic             n_stall;
    logic             pop;
    logic [CNT_W:0]   pending;

    assign pop     = (r_cnt != '0) && !i_stall;
    assign n_cnt   = r_cnt + CNT_W'(i_push) - CNT_W'(pop);
    // leave room for the result in flight and one more transfer
    assign pending = (CNT_W + 1)'(n_cnt) + (CNT_W + 1)'(i_push_next);
    assign n_stall = pending >= (CNT_W + 1)'(C_FIFO_DEPTH - 1);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
            r_stall  <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(C_FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(C_FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_cnt   <= n_cnt;
            r_stall <= n_stall;
        end
    end

    assign o_valid = r_cnt != '0;
    assign o_pixel = r_buf[r_rd_ptr];
    assign o_full  = r_stall;

    `LP2RGB_ASSERT_NOW(a_no_overflow, i_push && !pop, r_cnt < CNT_W'(C_FIFO_DEPTH), "output queue overflow")

endmodule

`default_nettype wire

[sim/tb_line_planar_to_rgb_interleave.sv]
module tb_line_planar_to_rgb_interleave;
    timeunit 1ns;
    timeprecision 1ps;

    import lp2rgb_pkg::*;

    localparam int MAX_W       = 4096;
    localparam int RAND_ITEMS  = 780;
    localparam int WIDE_BYTES  = 120;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 6;
    localparam int N_ROWS      = 27;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} t_stall_mode;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [7:0]            plane_byte;
        logic                  typed;
        t_pixel                px;
    } t_row;

    localparam t_pixel NO_PIXEL = '0;

    // one-pixel lines first, then a two-by-two image; junk above the width field is masked
    localparam t_row DIRECTED [N_ROWS] = '{
        '{1'b1, REG_LINE_WIDTH,   16'd1,   8'h00, 1'b0, NO_PIXEL},
        '{1'b1, REG_IMAGE_HEIGHT, 16'd1,   8'h00, 1'b0, NO_PIXEL},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'h00, 1'b0, NO_PIXEL},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'hFF, 1'b0, NO_PIXEL},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'hA5, 1'b1, '{8'h00, 8'hFF, 8'hA5, 1'b1}},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'hFF, 1'b0, NO_PIXEL},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'h00, 1'b0, NO_PIXEL},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'h5A, 1'b1, '{8'hFF, 8'h00, 8'h5A, 1'b1}},
        '{1'b1, REG_LINE_WIDTH,   16'hE000, 8'h00, 1'b0, NO_PIXEL},
        '{1'b1, REG_IMAGE_HEIGHT, 16'd0,   8'h00, 1'b0, NO_PIXEL},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'h01, 1'b0, NO_PIXEL},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'h02, 1'b0, NO_PIXEL},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'h80, 1'b1, '{8'h01, 8'h02, 8'h80, 1'b1}},
        '{1'b1, REG_LINE_WIDTH,   16'd2,   8'h00, 1'b0, NO_PIXEL},
        '{1'b1, REG_IMAGE_HEIGHT, 16'd2,   8'h00, 1'b0, NO_PIXEL},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'h11, 1'b0, NO_PIXEL},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'h22, 1'b0, NO_PIXEL},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'h33, 1'b0, NO_PIXEL},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'h44, 1'b0, NO_PIXEL},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'h55, 1'b1, '{8'h11, 8'h33, 8'h55, 1'b0}},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'h66, 1'b1, '{8'h22, 8'h44, 8'h66, 1'b0}},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'h77, 1'b0, NO_PIXEL},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'h88, 1'b0, NO_PIXEL},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'h99, 1'b0, NO_PIXEL},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'hAA, 1'b0, NO_PIXEL},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'hBB, 1'b1, '{8'h77, 8'h99, 8'hBB, 1'b0}},
        '{1'b0, REG_LINE_WIDTH,   '0,      8'hCC, 1'b1, '{8'h88, 8'hAA, 8'hCC, 1'b1}}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [7:0]            i_plane_byte;
    logic                  o_valid;
    logic                  i_stall;
    logic [7:0]            o_red;
    logic [7:0]            o_green;
    logic [7:0]            o_blue;
    logic                  o_image_end;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // converter shadow state
    logic [7:0]                red_line [MAX_W];
    logic [7:0]                green_line [MAX_W];
    logic [11:0]               col_cnt;
    logic [1:0]                plane;
    logic [15:0]               row_cnt;
    logic [LINE_WIDTH_W-1:0]   width_reg;
    logic [IMAGE_HEIGHT_W-1:0] height_reg;

    t_pixel      pixels_due [$];
    int          errors;
    int          gap_max;
    int          burst_left;
    int          hold_left;
    t_stall_mode stall_mode;
    int          stall_pct;
    logic [15:0] stall_pattern;

    line_planar_to_rgb_interleave i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_plane_byte (i_plane_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_image_end  (o_image_end),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned width_in_force();
        if (width_reg == '0) return 1;
        if (width_reg > MAX_W) return MAX_W;
        return 32'(width_reg);
    endfunction

    // advance the shadow by one byte; returns 1 when the byte makes a pixel
    function automatic bit convert_byte(input logic [7:0] b, output t_pixel px);
        int unsigned w;
        int unsigned h;
        bit          line_done;
        bit          last_row;
        bit          made;
        w = width_in_force();
        h = (height_reg == '0) ? 1 : 32'(height_reg);
        line_done = (col_cnt >= w - 1);
        last_row = (row_cnt >= h - 1);
        made = 1'b0;
        px = '0;
        case (plane)
            P_GREEN: green_line[col_cnt] = b;
            P_BLUE: begin
                px.red = red_line[col_cnt];
                px.green = green_line[col_cnt];
                px.blue = b;
                px.image_end = line_done && last_row;
                made = 1'b1;
            end
            default: red_line[col_cnt] = b;
        endcase
        if (line_done) begin
            col_cnt = '0;
            case (plane)
                P_BLUE: begin
                    plane = P_RED;
                    row_cnt = last_row ? '0 : row_cnt + 1'b1;
                end
                P_GREEN: plane = P_BLUE;
                default: plane = P_GREEN;
            endcase
        end else begin
            col_cnt = col_cnt + 1'b1;
            if (plane > P_BLUE) plane = P_RED;
        end
        return made;
    endfunction

    task automatic flag_error(input string what);
        errors++;
        if (errors <= 30) $display("ERROR at %0t: %s", $time, what);
    endtask

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic feed_byte(input logic [7:0] b, input bit typed, input t_pixel typed_px);
        int     gap;
        t_pixel px;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_plane_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (convert_byte(b, px) || typed) pixels_due.push_back(typed ? typed_px : px);
        burst_left--;
        @(negedge i_clk);
    endtask

    // drain all pixels, let the pipeline settle, then write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_valid <= 1'b0;
        while (pixels_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_LINE_WIDTH) width_reg = data[LINE_WIDTH_W-1:0];
        else height_reg = data[IMAGE_HEIGHT_W-1:0];
    endtask

    task automatic shuffle_idling();
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        stall_mode = t_stall_mode'($urandom_range(0, 2));
        stall_pct = $urandom_range(10, 75);
        stall_pattern = 16'($urandom) & 16'hFFFE;
    endtask

    // widen only at a row start, so the blue line never reads an unwritten column
    task automatic pick_settings(input bit both);
        logic [CFG_DATA_W-1:0] d;
        bit                    row_start;
        row_start = (plane == P_RED) && (col_cnt == '0);
        if (both || $urandom_range(0, 1) == 1) begin
            d = CFG_DATA_W'($urandom);
            if (row_start)
                d[LINE_WIDTH_W-1:0] = LINE_WIDTH_W'(($urandom_range(0, 7) == 0) ?
                                                    0 : $urandom_range(1, 16));
            else
                d[LINE_WIDTH_W-1:0] = LINE_WIDTH_W'($urandom_range(0, width_in_force()));
            write_register(REG_LINE_WIDTH, d);
        end
        if (both || $urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 9))
                0: d = '0;
                1: d = '1;
                2: d = CFG_DATA_W'($urandom_range(5, 40));
                default: d = CFG_DATA_W'($urandom_range(1, 4));
            endcase
            write_register(REG_IMAGE_HEIGHT, d);
        end
    endtask

    // receiver back-pressure
    initial begin
        int pat_pos;
        pat_pos = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    STALL_NONE: i_stall <= 1'b0;
                    STALL_RANDOM: i_stall <= ($urandom_range(0, 99) < stall_pct);
                    default: begin
                        i_stall <= stall_pattern[pat_pos];
                        pat_pos = (pat_pos + 1) % 16;
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixels_due.size() == 0) begin
                flag_error($sformatf("pixel %h %h %h %b with none expected",
                                     o_red, o_green, o_blue, o_image_end));
            end else begin
                want = pixels_due.pop_front();
                if (o_red !== want.red)
                    flag_error($sformatf("red got %h want %h", o_red, want.red));
                if (o_green !== want.green)
                    flag_error($sformatf("green got %h want %h", o_green, want.green));
                if (o_blue !== want.blue)
                    flag_error($sformatf("blue got %h want %h", o_blue, want.blue));
                if (o_image_end !== want.image_end)
                    flag_error($sformatf("image_end got %b want %b",
                                         o_image_end, want.image_end));
            end
        end
    end

    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int sent;
        int ph;
        int n;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_plane_byte = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        width_reg = LINE_WIDTH_W'(MAX_W);
        height_reg = 16'd1;
        col_cnt = '0;
        plane = P_RED;
        row_cnt = '0;
        errors = 0;
        gap_max = 0;
        burst_left = 0;
        hold_left = 0;
        stall_mode = STALL_NONE;
        stall_pct = 0;
        stall_pattern = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].is_cfg)
                write_register(DIRECTED[i].idx, DIRECTED[i].data);
            else
                feed_byte(DIRECTED[i].plane_byte, DIRECTED[i].typed, DIRECTED[i].px);
        end

        // wide red line: the largest legal width, then an out-of-range one
        write_register(REG_LINE_WIDTH, 16'd4096);
        write_register(REG_IMAGE_HEIGHT, 16'd1);
        shuffle_idling();
        repeat (WIDE_BYTES) feed_byte(8'($urandom_range(0, 255)), 1'b0, NO_PIXEL);
        write_register(REG_LINE_WIDTH, 16'h1FFF);
        write_register(REG_IMAGE_HEIGHT, 16'd0);
        shuffle_idling();
        repeat (WIDE_BYTES) feed_byte(8'($urandom_range(0, 255)), 1'b0, NO_PIXEL);
        // shrink the width to close the red line, then finish the row
        write_register(REG_LINE_WIDTH, 16'd1);
        while (!((plane == P_RED) && (col_cnt == '0)))
            feed_byte(8'($urandom_range(0, 255)), 1'b0, NO_PIXEL);

        sent = 0;
        ph = 0;
        while (sent < RAND_ITEMS) begin
            pick_settings(ph == 0);
            shuffle_idling();
            n = $urandom_range(1, 9 * width_in_force());
            if (ph == 3) begin
                // keep offering bytes while the output is held off
                gap_max = 0;
                hold_left = HOLD_CYCLES;
                n = 400;
            end
            repeat (n) feed_byte(8'($urandom_range(0, 255)), 1'b0, NO_PIXEL);
            sent += n;
            ph++;
        end

        i_valid <= 1'b0;
        while (pixels_due.size() != 0) @(negedge i_clk);
        repeat (4 * SETTLE) @(negedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
